### hdl/splt_pkg.sv
// Shared types and constants for the slot pool lifespan tracker.
// Used by slot_pool_lifespan_tracker_unit; depends on nothing.

package splt_pkg;

   localparam int SLOTS      = 64;
   localparam int SLOT_W     = 6;
   localparam int CNT_W      = 7;
   localparam int HASH_W     = 64;
   localparam int SIZE_W     = 48;
   localparam int TIME_W     = 48;
   localparam int KIND_W     = 3;
   localparam int MODE_W     = 2;
   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 224;

   // request modes
   localparam logic [MODE_W-1:0] MODE_TRACK    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FINALIZE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STOP     = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_TRACKED   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_POOL_FULL = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FINALIZED = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CENSORED  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NONE_LIVE = 3'd4;
   localparam logic [KIND_W-1:0] KIND_BAD_SLOT  = 3'd5;

   // one stored allocation record
   typedef struct packed {
      logic [HASH_W-1:0] hash;
      logic [SIZE_W-1:0] size;
      logic [TIME_W-1:0] birth;
   } rec_type;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_TRK_WR   = 7'b0000010,
      ST_FIN_OUT  = 7'b0000100,
      ST_ERR_OUT  = 7'b0001000,
      ST_SWP_SCAN = 7'b0010000,
      ST_SWP_LOAD = 7'b0100000,
      ST_SWP_END  = 7'b1000000
   } state_type;

endpackage

### hdl/slot_pool_lifespan_tracker_unit.sv
// Slot pool lifespan tracker: free-slot stack, record memory and sequencer.
// Depends on splt_pkg.
//
// Usage:
//   req channel: tuser carries the mode (track, finalize, stop); tdata carries
//   the hash, size, timestamp and slot number. One item is taken at a time;
//   req_tready is high only while the sequencer is idle.
//   rsp channel: one result per track or finalize item, one per live slot (or
//   one "none found") for a stop item; tlast marks the final result of an item.
//   csr port: a write of pool_capacity (clamped to 1..64) refills the free
//   stack and clears all slot marks at once; write only while idle.
// Sequencing:
//   track and finalize items read the free-stack or record memory on accept,
//   refused items read nothing; a second state loads the output register.
//   A stop item scans one slot per cycle over the pool capacity unless the
//   output stalls it, and passes a load state per live slot for its record
//   read, then an end state. The single read port of each memory sets the rate.
// Reset: capacity 64, all slots free, no marks set; no clearing pass is
//   needed, the stack's initial contents are implied by a low-water count.
// Stall: each state that loads a result holds while the output register is full
//   and rsp_tready is low; no result is dropped.

module slot_pool_lifespan_tracker_unit (
   input  logic                            clock,
   input  logic                            reset,
   // slave side
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // site_hash[63:0], object_size[111:64], now_time[159:112], slot_index[165:160]
   input  logic [splt_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode[1:0]
   input  logic [splt_pkg::MODE_W-1:0]     req_tuser,
   // master side
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // slot_out[5:0], hash_out[69:6], size_out[117:70], birth_time[165:118],
   // death_time[213:166], free_slots[220:214]
   output logic [splt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // result_kind[2:0]
   output logic [splt_pkg::KIND_W-1:0]     rsp_tuser,
   // last_of_run
   output logic                            rsp_tlast,
   // configuration
   input  logic                            csr_wr_en,
   input  logic [splt_pkg::CNT_W-1:0]      csr_wr_data
);

   localparam int SW = splt_pkg::SLOT_W;
   localparam int CW = splt_pkg::CNT_W;
   localparam int TW = splt_pkg::TIME_W;

   // request field split
   logic [splt_pkg::HASH_W-1:0] req_hash;
   logic [splt_pkg::SIZE_W-1:0] req_size;
   logic [TW-1:0]               req_now;
   logic [SW-1:0]               req_slot;

   assign req_hash = req_tdata[63:0];
   assign req_size = req_tdata[111:64];
   assign req_now  = req_tdata[159:112];
   assign req_slot = req_tdata[165:160];

   // control state
   splt_pkg::state_type state_ff, state_in;
   logic [CW-1:0]           cap_ff, cap_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [CW-1:0]           lw_ff, lw_in;        // lowest stack count since refill
   logic [splt_pkg::SLOTS-1:0] live_ff, live_in;
   logic [splt_pkg::SLOTS-1:0] held_ff, held_in;
   logic [SW-1:0]           scan_ff, scan_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic                    out_valid_ff, out_valid_in;

   // operation payload
   logic [SW-1:0]                  op_slot_ff, op_slot_in;
   logic [splt_pkg::KIND_W-1:0]    op_kind_ff, op_kind_in;
   logic [TW-1:0]                  op_time_ff, op_time_in;
   logic [splt_pkg::HASH_W-1:0]    op_hash_ff, op_hash_in;
   logic [splt_pkg::SIZE_W-1:0]    op_size_ff, op_size_in;
   logic                           use_init_ff, use_init_in;
   logic [SW-1:0]                  init_val_ff, init_val_in;
   splt_pkg::rec_type              pend_rec_ff, pend_rec_in;
   logic [SW-1:0]                  pend_slot_ff, pend_slot_in;

   // output register
   logic [splt_pkg::KIND_W-1:0]    out_kind_ff, out_kind_in;
   logic [SW-1:0]                  out_slot_ff, out_slot_in;
   splt_pkg::rec_type              out_rec_ff, out_rec_in;
   logic [TW-1:0]                  out_death_ff, out_death_in;
   logic [CW-1:0]                  out_free_ff, out_free_in;
   logic                           out_last_ff, out_last_in;

   // memories
   logic [SW-1:0]           stk_mem [splt_pkg::SLOTS];
   splt_pkg::rec_type       rec_mem [splt_pkg::SLOTS];
   logic [SW-1:0]           stk_rd_ff;
   splt_pkg::rec_type       rec_rd_ff;
   logic                    stk_we, stk_re, rec_we, rec_re;
   logic [SW-1:0]           stk_waddr, stk_raddr, rec_waddr, rec_raddr;
   logic [SW-1:0]           stk_wdata;
   splt_pkg::rec_type       rec_wdata;

   logic                    out_room;
   logic [CW-1:0]           pop_pos;
   logic [CW-1:0]           cap_last;
   logic [CW-1:0]           cfg_cap;
   logic [SW-1:0]           trk_slot;

   assign req_tready = (state_ff == splt_pkg::ST_IDLE);
   assign out_room   = !out_valid_ff || rsp_tready;
   assign pop_pos    = cnt_ff - CW'(1);
   assign cap_last   = cap_ff - CW'(1);
   assign trk_slot   = use_init_ff ? init_val_ff : stk_rd_ff;

   // clamp of a capacity write to 1..SLOTS
   always_comb begin
      if (csr_wr_data == '0) begin
         cfg_cap = CW'(1);
      end else if (csr_wr_data > CW'(splt_pkg::SLOTS)) begin
         cfg_cap = CW'(splt_pkg::SLOTS);
      end else begin
         cfg_cap = csr_wr_data;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      cnt_in        = cnt_ff;
      lw_in         = lw_ff;
      live_in       = live_ff;
      held_in       = held_ff;
      scan_in       = scan_ff;
      pend_valid_in = pend_valid_ff;
      op_slot_in    = op_slot_ff;
      op_kind_in    = op_kind_ff;
      op_time_in    = op_time_ff;
      op_hash_in    = op_hash_ff;
      op_size_in    = op_size_ff;
      use_init_in   = use_init_ff;
      init_val_in   = init_val_ff;
      pend_rec_in   = pend_rec_ff;
      pend_slot_in  = pend_slot_ff;

      out_valid_in  = out_valid_ff && !rsp_tready;
      out_kind_in   = out_kind_ff;
      out_slot_in   = out_slot_ff;
      out_rec_in    = out_rec_ff;
      out_death_in  = out_death_ff;
      out_free_in   = out_free_ff;
      out_last_in   = out_last_ff;

      stk_we    = 1'b0;
      stk_waddr = cnt_ff[SW-1:0];
      stk_wdata = op_slot_ff;
      stk_re    = 1'b0;
      stk_raddr = pop_pos[SW-1:0];
      rec_we    = 1'b0;
      rec_waddr = trk_slot;
      rec_wdata = '{hash: op_hash_ff, size: op_size_ff, birth: op_time_ff};
      rec_re    = 1'b0;
      rec_raddr = req_slot;

      case (state_ff)
         splt_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_slot_in = req_slot;
               op_time_in = req_now;
               op_hash_in = req_hash;
               op_size_in = req_size;
               case (req_tuser)
                  splt_pkg::MODE_TRACK: begin
                     if (cnt_ff == '0) begin
                        op_kind_in = splt_pkg::KIND_POOL_FULL;
                        op_slot_in = '0;
                        state_in   = splt_pkg::ST_ERR_OUT;
                     end else begin
                        // pop: untouched stack entries hold their refill value
                        stk_re      = 1'b1;
                        cnt_in      = pop_pos;
                        use_init_in = (pop_pos < lw_ff);
                        init_val_in = SW'(cap_last - pop_pos);
                        if (pop_pos < lw_ff) begin
                           lw_in = pop_pos;
                        end
                        state_in = splt_pkg::ST_TRK_WR;
                     end
                  end
                  splt_pkg::MODE_FINALIZE: begin
                     if ({1'b0, req_slot} >= cap_ff ||
                         !(live_ff[req_slot] || held_ff[req_slot])) begin
                        op_kind_in = splt_pkg::KIND_BAD_SLOT;
                        state_in   = splt_pkg::ST_ERR_OUT;
                     end else begin
                        live_in[req_slot] = 1'b0;
                        held_in[req_slot] = 1'b0;
                        rec_re = 1'b1;
                        if (cnt_ff < cap_ff) begin
                           stk_we    = 1'b1;
                           stk_wdata = req_slot;
                           cnt_in    = cnt_ff + CW'(1);
                        end
                        state_in = splt_pkg::ST_FIN_OUT;
                     end
                  end
                  splt_pkg::MODE_STOP: begin
                     scan_in       = '0;
                     pend_valid_in = 1'b0;
                     state_in      = splt_pkg::ST_SWP_SCAN;
                  end
                  default: begin
                     state_in = splt_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         splt_pkg::ST_TRK_WR: begin
            if (out_room) begin
               rec_we            = 1'b1;
               live_in[trk_slot] = 1'b1;
               held_in[trk_slot] = 1'b0;
               out_valid_in      = 1'b1;
               out_kind_in       = splt_pkg::KIND_TRACKED;
               out_slot_in       = trk_slot;
               out_rec_in        = rec_wdata;
               out_death_in      = '0;
               out_free_in       = cnt_ff;
               out_last_in       = 1'b1;
               state_in          = splt_pkg::ST_IDLE;
            end
         end

         splt_pkg::ST_FIN_OUT: begin
            if (out_room) begin
               out_valid_in = 1'b1;
               out_kind_in  = splt_pkg::KIND_FINALIZED;
               out_slot_in  = op_slot_ff;
               out_rec_in   = rec_rd_ff;
               out_death_in = op_time_ff;
               out_free_in  = cnt_ff;
               out_last_in  = 1'b1;
               state_in     = splt_pkg::ST_IDLE;
            end
         end

         splt_pkg::ST_ERR_OUT: begin
            if (out_room) begin
               out_valid_in = 1'b1;
               out_kind_in  = op_kind_ff;
               out_slot_in  = op_slot_ff;
               out_rec_in   = '0;
               out_death_in = '0;
               out_free_in  = cnt_ff;
               out_last_in  = 1'b1;
               state_in     = splt_pkg::ST_IDLE;
            end
         end

         // one slot per cycle while no live slot is found; a live slot is moved to held and its record read
         splt_pkg::ST_SWP_SCAN: begin
            rec_raddr = scan_ff;
            if (live_ff[scan_ff]) begin
               live_in[scan_ff] = 1'b0;
               held_in[scan_ff] = 1'b1;
               rec_re   = 1'b1;
               state_in = splt_pkg::ST_SWP_LOAD;
            end else if ({1'b0, scan_ff} == cap_last) begin
               state_in = splt_pkg::ST_SWP_END;
            end else begin
               scan_in = scan_ff + SW'(1);
            end
         end

         // the previous find goes out (not last); this one becomes pending
         splt_pkg::ST_SWP_LOAD: begin
            if (!pend_valid_ff || out_room) begin
               if (pend_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_kind_in  = splt_pkg::KIND_CENSORED;
                  out_slot_in  = pend_slot_ff;
                  out_rec_in   = pend_rec_ff;
                  out_death_in = '0;
                  out_free_in  = cnt_ff;
                  out_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_rec_in   = rec_rd_ff;
               pend_slot_in  = scan_ff;
               if ({1'b0, scan_ff} == cap_last) begin
                  state_in = splt_pkg::ST_SWP_END;
               end else begin
                  scan_in  = scan_ff + SW'(1);
                  state_in = splt_pkg::ST_SWP_SCAN;
               end
            end
         end

         splt_pkg::ST_SWP_END: begin
            if (out_room) begin
               out_valid_in = 1'b1;
               out_death_in = '0;
               out_free_in  = cnt_ff;
               out_last_in  = 1'b1;
               if (pend_valid_ff) begin
                  out_kind_in = splt_pkg::KIND_CENSORED;
                  out_slot_in = pend_slot_ff;
                  out_rec_in  = pend_rec_ff;
               end else begin
                  out_kind_in = splt_pkg::KIND_NONE_LIVE;
                  out_slot_in = '0;
                  out_rec_in  = '0;
               end
               pend_valid_in = 1'b0;
               state_in      = splt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = splt_pkg::ST_IDLE;
         end
      endcase

      // capacity write: refill the stack and clear all marks
      if (csr_wr_en) begin
         cap_in  = cfg_cap;
         cnt_in  = cfg_cap;
         lw_in   = cfg_cap;
         live_in = '0;
         held_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= splt_pkg::ST_IDLE;
         cap_ff        <= CW'(splt_pkg::SLOTS);
         cnt_ff        <= CW'(splt_pkg::SLOTS);
         lw_ff         <= CW'(splt_pkg::SLOTS);
         live_ff       <= '0;
         held_ff       <= '0;
         scan_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         cnt_ff        <= cnt_in;
         lw_ff         <= lw_in;
         live_ff       <= live_in;
         held_ff       <= held_in;
         scan_ff       <= scan_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_slot_ff   <= op_slot_in;
      op_kind_ff   <= op_kind_in;
      op_time_ff   <= op_time_in;
      op_hash_ff   <= op_hash_in;
      op_size_ff   <= op_size_in;
      use_init_ff  <= use_init_in;
      init_val_ff  <= init_val_in;
      pend_rec_ff  <= pend_rec_in;
      pend_slot_ff <= pend_slot_in;
      out_kind_ff  <= out_kind_in;
      out_slot_ff  <= out_slot_in;
      out_rec_ff   <= out_rec_in;
      out_death_ff <= out_death_in;
      out_free_ff  <= out_free_in;
      out_last_ff  <= out_last_in;
   end

   // free-slot stack memory, registered read
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rd_ff <= stk_mem[stk_raddr];
      end
   end

   // record memory, registered read
   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[rec_waddr] <= rec_wdata;
      end
      if (rec_re) begin
         rec_rd_ff <= rec_mem[rec_raddr];
      end
   end

   // result channel
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {3'b000, out_free_ff, out_death_ff, out_rec_ff.birth,
                        out_rec_ff.size, out_rec_ff.hash, out_slot_ff};

endmodule

### dv/tb_slot_pool_lifespan_tracker_unit.sv
// Self-checking testbench for slot_pool_lifespan_tracker_unit: drives track, finalize
// and stop items plus capacity writes, predicts every result and checks each one.
// Depends on splt_pkg and the tracker RTL.
`timescale 1ns / 1ps

module tb_slot_pool_lifespan_tracker_unit;
   import splt_pkg::*;

   localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int DRAIN_CYCLES = 300;
   localparam int RANDOM_PER_CAP = 12;
   localparam logic [10:0] STALL_PATTERN = 11'b10110011101;

   // one request item
   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [HASH_W-1:0] hash;
      logic [SIZE_W-1:0] size;
      logic [TIME_W-1:0] now;
      logic [SLOT_W-1:0] slot;
   } pool_req_t;

   // one result item
   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] slot;
      logic [HASH_W-1:0] hash;
      logic [SIZE_W-1:0] size;
      logic [TIME_W-1:0] birth;
      logic [TIME_W-1:0] death;
      logic [CNT_W-1:0]  free;
      logic              last;
   } pool_result_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [MODE_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wr_en = 1'b0;
   logic [CNT_W-1:0]      csr_wr_data = '0;

   // shadow copy of the pool
   logic [HASH_W-1:0] rec_hash [SLOTS];
   logic [SIZE_W-1:0] rec_size [SLOTS];
   logic [TIME_W-1:0] rec_birth [SLOTS];
   logic              is_live [SLOTS];
   logic              is_swept [SLOTS];
   logic [SLOT_W-1:0] free_list [SLOTS];
   int                stack_fill;
   int                cap;

   pool_result_t awaited_results[$];
   int           err_count = 0;
   int           cycle_count = 0;

   // receiver control: style of stalls and a long hold-off counter
   int rx_mode = 0;
   int hold_left = 0;
   int rx_tick = 0;

   slot_pool_lifespan_tracker_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // watchdog
   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) @(posedge clock);
      $display("*** FAILED ***");
      $finish;
   end

   // receiver stall patterns
   always @(negedge clock) begin
      rx_tick = rx_tick + 1;
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left = hold_left - 1;
      end else begin
         case (rx_mode)
            1: rsp_tready = ($urandom_range(0, 9) < 7);
            2: rsp_tready = ($urandom_range(0, 9) < 3);
            3: rsp_tready = STALL_PATTERN[rx_tick % 11];
            default: rsp_tready = 1'b1;
         endcase
      end
   end

   // capacity write side effects: clamp, clear marks, refill the stack
   function automatic void reload_pool(input int value);
      int i;
      cap = (value < 1) ? 1 : (value > SLOTS) ? SLOTS : value;
      for (i = 0; i < SLOTS; i++) begin
         is_live[i] = 1'b0;
         is_swept[i] = 1'b0;
      end
      for (i = 0; i < cap; i++) free_list[i] = SLOT_W'(cap - 1 - i);
      stack_fill = cap;
   endfunction

   function automatic pool_result_t make_result(input logic [KIND_W-1:0] kind,
                                                input logic [SLOT_W-1:0] slot,
                                                input logic [HASH_W-1:0] hash,
                                                input logic [SIZE_W-1:0] size,
                                                input logic [TIME_W-1:0] birth,
                                                input logic [TIME_W-1:0] death,
                                                input logic last);
      pool_result_t r;
      r.kind = kind;
      r.slot = slot;
      r.hash = hash;
      r.size = size;
      r.birth = birth;
      r.death = death;
      r.free = CNT_W'(stack_fill);
      r.last = last;
      return r;
   endfunction

   // predicts the results of one accepted item and queues them
   function automatic void pool_predict(input pool_req_t it);
      int s;
      int i;
      int found;
      found = 0;
      s = int'(it.slot);
      case (it.mode)
         MODE_TRACK: begin
            if (stack_fill == 0) begin
               awaited_results = {awaited_results,
                                  make_result(KIND_POOL_FULL, '0, '0, '0, '0, '0, 1'b1)};
            end else begin
               stack_fill = stack_fill - 1;
               s = int'(free_list[stack_fill]);
               is_live[s] = 1'b1;
               is_swept[s] = 1'b0;
               rec_hash[s] = it.hash;
               rec_size[s] = it.size;
               rec_birth[s] = it.now;
               awaited_results = {awaited_results,
                                  make_result(KIND_TRACKED, SLOT_W'(s), it.hash, it.size,
                                              it.now, '0, 1'b1)};
            end
         end
         MODE_FINALIZE: begin
            if (s >= cap || !(is_live[s] || is_swept[s])) begin
               awaited_results = {awaited_results,
                                  make_result(KIND_BAD_SLOT, SLOT_W'(s), '0, '0, '0, '0,
                                              1'b1)};
            end else begin
               is_live[s] = 1'b0;
               is_swept[s] = 1'b0;
               if (stack_fill < cap) begin
                  free_list[stack_fill] = SLOT_W'(s);
                  stack_fill = stack_fill + 1;
               end
               awaited_results = {awaited_results,
                                  make_result(KIND_FINALIZED, SLOT_W'(s), rec_hash[s],
                                              rec_size[s], rec_birth[s], it.now, 1'b1)};
            end
         end
         MODE_STOP: begin
            for (i = 0; i < cap; i++) begin
               if (is_live[i]) begin
                  is_live[i] = 1'b0;
                  is_swept[i] = 1'b1;
                  awaited_results = {awaited_results,
                                     make_result(KIND_CENSORED, SLOT_W'(i), rec_hash[i],
                                                 rec_size[i], rec_birth[i], '0, 1'b0)};
                  found = found + 1;
               end
            end
            if (found == 0)
               awaited_results = {awaited_results,
                                  make_result(KIND_NONE_LIVE, '0, '0, '0, '0, '0, 1'b1)};
            else
               awaited_results[awaited_results.size() - 1].last = 1'b1;
         end
         default: ;
      endcase
   endfunction

   // result checker
   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         err_count = err_count + 1;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      pool_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            $error("result with nothing expected: kind %0d slot %0d", rsp_tuser,
                   rsp_tdata[5:0]);
            err_count = err_count + 1;
         end else begin
            want = awaited_results[0];
            awaited_results.delete(0);
            check_field("result_kind", 64'(want.kind), 64'(rsp_tuser));
            check_field("slot_out", 64'(want.slot), 64'(rsp_tdata[5:0]));
            check_field("hash_out", want.hash, rsp_tdata[69:6]);
            check_field("size_out", 64'(want.size), 64'(rsp_tdata[117:70]));
            check_field("birth_time", 64'(want.birth), 64'(rsp_tdata[165:118]));
            check_field("death_time", 64'(want.death), 64'(rsp_tdata[213:166]));
            check_field("free_slots", 64'(want.free), 64'(rsp_tdata[220:214]));
            check_field("last_of_run", 64'(want.last), 64'(rsp_tlast));
         end
      end
   end

   function automatic logic [47:0] rand48();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[47:0];
   endfunction

   // sends one item; with follow set the valid stays high for the next one
   task automatic send_item(input pool_req_t it, input bit follow);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = it.mode;
      req_tdata = {2'b00, it.slot, it.now, it.size, it.hash};
      do @(posedge clock); while (!req_tready);
      pool_predict(it);
      if (!follow) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
   endtask

   task automatic idle_sender(input int cycles);
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_drained();
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic hold_receiver(input int cycles);
      @(posedge clock);
      hold_left = cycles;
   endtask

   // capacity write, only once the block is idle
   task automatic write_capacity(input logic [CNT_W-1:0] value);
      wait_drained();
      repeat (8) @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(posedge clock);
      reload_pool(int'(value));
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic pool_req_t make_req(input logic [MODE_W-1:0] mode,
                                          input logic [HASH_W-1:0] hash,
                                          input logic [SIZE_W-1:0] size,
                                          input logic [TIME_W-1:0] now,
                                          input logic [SLOT_W-1:0] slot);
      pool_req_t it;
      it.mode = mode;
      it.hash = hash;
      it.size = size;
      it.now = now;
      it.slot = slot;
      return it;
   endfunction

   // random item: mostly tracks and finalizes of slots that hold a record
   function automatic pool_req_t random_item();
      pool_req_t it;
      int pick;
      int start;
      int k;
      int s;
      it = make_req(MODE_TRACK, {$urandom, $urandom}, rand48(), rand48(),
                    SLOT_W'($urandom_range(0, 63)));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         it.mode = MODE_TRACK;
      end else if (pick < 75) begin
         it.mode = MODE_FINALIZE;
         start = $urandom_range(0, 63);
         for (k = 0; k < SLOTS; k++) begin
            s = (start + k) % SLOTS;
            if (s < cap && (is_live[s] || is_swept[s])) begin
               it.slot = SLOT_W'(s);
               break;
            end
         end
      end else if (pick < 83) begin
         it.mode = MODE_STOP;
      end else if (pick < 95) begin
         it.mode = MODE_FINALIZE;
      end else begin
         it.mode = MODE_IGNORED;
      end
      return it;
   endfunction

   // extremes of the fields, every mode, bad slots, held slots, empty sweep
   task automatic test_directed_modes();
      rx_mode = 0;
      send_item(make_req(MODE_TRACK, '1, '1, '1, '0), 0);
      send_item(make_req(MODE_TRACK, '0, '0, '0, '1), 0);
      send_item(make_req(MODE_FINALIZE, '0, '0, '1, '0), 0);
      // finalize of a free slot
      send_item(make_req(MODE_FINALIZE, '1, '1, '1, '0), 0);
      // finalize of a slot never tracked
      send_item(make_req(MODE_FINALIZE, '0, '0, 48'd5, 6'd63), 0);
      send_item(make_req(MODE_STOP, '1, '1, '1, '1), 0);
      // finalize of a swept slot
      send_item(make_req(MODE_FINALIZE, '0, '0, 48'h123456789abc, 6'd1), 0);
      send_item(make_req(MODE_STOP, '0, '0, '0, '0), 0);
      send_item(make_req(MODE_IGNORED, '1, '1, '1, '1), 0);
      send_item(make_req(MODE_TRACK, 64'h0123456789abcdef, 48'h5555aaaa5555,
                         48'haaaa5555aaaa, '0), 0);
      wait_drained();
   endtask

   // capacity clamping, pool full, slot beyond capacity
   task automatic test_capacity_edges();
      write_capacity(7'd0);
      send_item(make_req(MODE_TRACK, 64'hfeedface, 48'd100, 48'd1, '0), 0);
      send_item(make_req(MODE_TRACK, 64'hdeadbeef, 48'd200, 48'd2, '0), 0);
      send_item(make_req(MODE_FINALIZE, '0, '0, 48'd3, 6'd1), 0);
      send_item(make_req(MODE_FINALIZE, '0, '0, 48'd4, '0), 0);
      send_item(make_req(MODE_STOP, '0, '0, '0, '0), 0);
      write_capacity(7'd127);
      send_item(make_req(MODE_TRACK, 64'h1, 48'd1, 48'd10, '0), 0);
      write_capacity(7'd2);
      send_item(make_req(MODE_TRACK, 64'h2, 48'd2, 48'd20, '0), 0);
      send_item(make_req(MODE_TRACK, 64'h3, 48'd3, 48'd30, '0), 0);
      send_item(make_req(MODE_TRACK, 64'h4, 48'd4, 48'd40, '0), 0);
      send_item(make_req(MODE_STOP, '0, '0, '0, '0), 0);
      send_item(make_req(MODE_FINALIZE, '0, '0, 48'd50, 6'd1), 0);
      send_item(make_req(MODE_FINALIZE, '0, '0, 48'd60, '0), 0);
      wait_drained();
   endtask

   // long receiver hold-offs over a pool overfill, a full sweep and finalizes
   task automatic test_output_backpressure();
      int n;
      write_capacity(7'd64);
      rx_mode = 0;
      hold_receiver(500);
      for (n = 0; n < SLOTS + 2; n++)
         send_item(make_req(MODE_TRACK, {$urandom, $urandom}, rand48(), rand48(), '0), 1);
      send_item(make_req(MODE_STOP, '0, '0, '0, '0), 0);
      wait_drained();
      hold_receiver(200);
      for (n = 0; n < 8; n++)
         send_item(make_req(MODE_FINALIZE, '0, '0, rand48(), SLOT_W'(n * 7)), 1);
      send_item(make_req(MODE_STOP, '0, '0, '0, '0), 0);
      wait_drained();
   endtask

   // random traffic in bursts over several capacities and stall styles
   task automatic test_random_traffic();
      int caps[7];
      int p;
      int counted;
      int burst_left;
      pool_req_t it;
      caps = '{64, 0, 2, 127, 5, 100, 17};
      burst_left = 0;
      for (p = 0; p < 7; p++) begin
         write_capacity(CNT_W'(caps[p]));
         rx_mode = p % 4;
         counted = 0;
         while (counted < RANDOM_PER_CAP) begin
            it = random_item();
            if (it.mode != MODE_IGNORED) counted = counted + 1;
            if (burst_left == 0) begin
               idle_sender($urandom_range(1, 6));
               burst_left = ($urandom_range(0, 3) == 0) ? 24 : $urandom_range(1, 10);
            end
            burst_left = burst_left - 1;
            send_item(it, burst_left > 0 && counted < RANDOM_PER_CAP);
         end
      end
      wait_drained();
   endtask

   initial begin
      reload_pool(SLOTS);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_modes();
      test_capacity_edges();
      test_output_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0) begin
         $error("%0d results never arrived", awaited_results.size());
         err_count = err_count + 1;
      end
      if (err_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
